@@ rtl/ale_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types and codes for the array list engine.
// ----------------------------------------------------------------------------
package ale_pkg;

    typedef enum logic [2:0] {
        CMD_GET     = 3'd0,
        CMD_REPLACE = 3'd1,
        CMD_INSERT  = 3'd2,
        CMD_PUSH    = 3'd3,
        CMD_REMOVE  = 3'd4,
        CMD_SORT    = 3'd5,
        CMD_LSEARCH = 3'd6,
        CMD_BSEARCH = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd               command;
        logic [6:0]         index;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] read_value;
        logic [6:0]         found_position;
        logic [7:0]         element_count;
    } t_rsp;

endpackage

@@ rtl/ale_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_req_if / ale_rsp_if
// Valid/ready channels carrying command and result words.
// ----------------------------------------------------------------------------
interface ale_req_if;
    import ale_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ale_rsp_if;
    import ale_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/ale_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

@@ rtl/ale_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_core
// Command sequencer: walks the store through the RAM.
// ----------------------------------------------------------------------------
module ale_core #(
    parameter int DEPTH     = 128,
    parameter int WORD_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    output logic                     o_req_ready,
    input  ale_pkg::t_req            i_req,
    output logic                     o_rsp_valid,
    input  logic                     i_rsp_ready,
    output ale_pkg::t_rsp            o_rsp,
    output logic [$clog2(DEPTH)-1:0] o_rd_addr,
    input  logic [WORD_BITS-1:0]     i_rd_data,
    output logic                     o_we,
    output logic [$clog2(DEPTH)-1:0] o_wr_addr,
    output logic [WORD_BITS-1:0]     o_wr_data
);
    import ale_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_GET, S_INS_WR, S_INS_FIN, S_REM_WR,
        S_SRT_K, S_SRT_M, S_SRT_WK, S_LIN, S_BIN, S_DONE
    } t_state;

    t_state                r_state, n_state;
    t_cmd                  r_cmd;
    logic [CMPW-1:0]       r_idx;
    logic [WORD_BITS-1:0]  r_word;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_k, n_k;
    logic [CW-1:0]         r_m, n_m;
    logic [CW-1:0]         r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [WORD_BITS-1:0]  r_a, n_a;
    t_status               r_st, n_st;
    logic [31:0]           r_rv, n_rv;
    logic [CW-1:0]         r_pos, n_pos;
    logic                  r_ovalid;
    t_rsp                  r_rsp;

    logic [CMPW-1:0] cnt_ext;
    logic [CW-1:0]   idx_c;
    logic [CW-1:0]   k_dn, k_up, m_up, lo_up;

    assign cnt_ext = CMPW'(r_count);
    assign idx_c   = r_idx[CW-1:0];
    assign k_dn    = r_k - CW'(1);
    assign k_up    = r_k + CW'(1);
    assign m_up    = r_m + CW'(1);
    assign lo_up   = r_mid + CW'(1);

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_ovalid;
    assign o_rsp       = r_rsp;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_k       = r_k;
        n_m       = r_m;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_a       = r_a;
        n_st      = r_st;
        n_rv      = r_rv;
        n_pos     = r_pos;
        o_rd_addr = r_k[AW-1:0];
        o_we      = 1'b0;
        o_wr_addr = r_k[AW-1:0];
        o_wr_data = r_word;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_START;
                    n_st    = ST_OK;
                    n_rv    = '0;
                    n_pos   = '0;
                end
            end
            S_START: begin
                n_state = S_DONE;
                case (r_cmd)
                    CMD_GET: begin
                        if (r_idx >= cnt_ext) begin
                            n_st = ST_RANGE;
                        end else begin
                            o_rd_addr = r_idx[AW-1:0];
                            n_state   = S_GET;
                        end
                    end
                    CMD_REPLACE: begin
                        if (r_idx >= cnt_ext) begin
                            n_st = ST_RANGE;
                        end else begin
                            o_we      = 1'b1;
                            o_wr_addr = r_idx[AW-1:0];
                        end
                    end
                    CMD_INSERT: begin
                        if (r_idx > cnt_ext) begin
                            n_st = ST_RANGE;
                        end else if (r_count == CW'(DEPTH)) begin
                            n_st = ST_FULL;
                        end else if (r_idx == cnt_ext) begin
                            o_we      = 1'b1;
                            o_wr_addr = r_count[AW-1:0];
                            n_count   = r_count + CW'(1);
                        end else begin
                            n_k       = r_count;
                            o_rd_addr = AW'(r_count - CW'(1));
                            n_state   = S_INS_WR;
                        end
                    end
                    CMD_PUSH: begin
                        if (r_count == CW'(DEPTH)) begin
                            n_st = ST_FULL;
                        end else begin
                            o_we      = 1'b1;
                            o_wr_addr = r_count[AW-1:0];
                            n_count   = r_count + CW'(1);
                        end
                    end
                    CMD_REMOVE: begin
                        if (r_idx >= cnt_ext) begin
                            n_st = ST_RANGE;
                        end else if (CMPW'(idx_c + CW'(1)) >= cnt_ext) begin
                            n_count = r_count - CW'(1);
                        end else begin
                            n_k       = idx_c;
                            o_rd_addr = AW'(idx_c + CW'(1));
                            n_state   = S_REM_WR;
                        end
                    end
                    CMD_SORT: begin
                        if (r_count > CW'(1)) begin
                            n_k       = '0;
                            o_rd_addr = '0;
                            n_state   = S_SRT_K;
                        end
                    end
                    CMD_LSEARCH: begin
                        if (r_count == '0) begin
                            n_st = ST_NOTFOUND;
                        end else begin
                            n_k       = '0;
                            o_rd_addr = '0;
                            n_state   = S_LIN;
                        end
                    end
                    default: begin
                        if (r_count == '0) begin
                            n_st = ST_NOTFOUND;
                        end else begin
                            n_lo      = '0;
                            n_hi      = r_count;
                            n_mid     = (r_count - CW'(1)) >> 1;
                            o_rd_addr = AW'((r_count - CW'(1)) >> 1);
                            n_state   = S_BIN;
                        end
                    end
                endcase
            end
            S_GET: begin
                n_rv    = 32'($signed(i_rd_data));
                n_state = S_DONE;
            end
            S_INS_WR: begin
                o_we      = 1'b1;
                o_wr_addr = r_k[AW-1:0];
                o_wr_data = i_rd_data;
                n_k       = k_dn;
                o_rd_addr = AW'(k_dn - CW'(1));
                if (k_dn == idx_c) begin
                    n_state = S_INS_FIN;
                end
            end
            S_INS_FIN: begin
                o_we      = 1'b1;
                o_wr_addr = r_k[AW-1:0];
                n_count   = r_count + CW'(1);
                n_state   = S_DONE;
            end
            S_REM_WR: begin
                o_we      = 1'b1;
                o_wr_addr = r_k[AW-1:0];
                o_wr_data = i_rd_data;
                n_k       = k_up;
                o_rd_addr = AW'(k_up + CW'(1));
                if (k_up + CW'(1) >= r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_SRT_K: begin
                n_a       = i_rd_data;
                n_m       = k_up;
                o_rd_addr = k_up[AW-1:0];
                n_state   = S_SRT_M;
            end
            S_SRT_M: begin
                if ($signed(r_a) > $signed(i_rd_data)) begin
                    o_we      = 1'b1;
                    o_wr_addr = r_m[AW-1:0];
                    o_wr_data = r_a;
                    n_a       = i_rd_data;
                end
                n_m       = m_up;
                o_rd_addr = m_up[AW-1:0];
                if (m_up >= r_count) begin
                    n_state = S_SRT_WK;
                end
            end
            S_SRT_WK: begin
                o_we      = 1'b1;
                o_wr_addr = r_k[AW-1:0];
                o_wr_data = r_a;
                n_k       = k_up;
                o_rd_addr = k_up[AW-1:0];
                if (k_up + CW'(1) < r_count) begin
                    n_state = S_SRT_K;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LIN: begin
                n_k       = k_up;
                o_rd_addr = k_up[AW-1:0];
                if (i_rd_data == r_word) begin
                    n_pos   = r_k;
                    n_state = S_DONE;
                end else if (k_up >= r_count) begin
                    n_st    = ST_NOTFOUND;
                    n_state = S_DONE;
                end
            end
            S_BIN: begin
                if (i_rd_data == r_word) begin
                    n_pos   = r_mid;
                    n_state = S_DONE;
                end else begin
                    if ($signed(r_word) > $signed(i_rd_data)) begin
                        n_lo = lo_up;
                    end else begin
                        n_hi = r_mid;
                    end
                    n_mid     = n_lo + ((n_hi - CW'(1) - n_lo) >> 1);
                    o_rd_addr = n_mid[AW-1:0];
                    if (n_lo >= n_hi) begin
                        n_st    = ST_NOTFOUND;
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_DONE && (!r_ovalid || i_rsp_ready)) begin
                r_ovalid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (r_state == S_IDLE && i_req_valid) begin
            r_cmd  <= i_req.command;
            r_idx  <= CMPW'(i_req.index);
            r_word <= WORD_BITS'(i_req.value);
        end
        if (r_state == S_DONE && (!r_ovalid || i_rsp_ready)) begin
            r_rsp.status         <= r_st;
            r_rsp.read_value     <= r_rv;
            r_rsp.found_position <= 7'(r_pos);
            r_rsp.element_count  <= 8'(r_count);
        end
        r_k   <= n_k;
        r_m   <= n_m;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_a   <= n_a;
        r_st  <= n_st;
        r_rv  <= n_rv;
        r_pos <= n_pos;
    end

endmodule

@@ rtl/array_list_engine_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_engine_unit
// Array list of signed words: get, replace, insert, push, remove, sort,
// linear and binary search, one result word per command word.
//
//   channel  dir  word
//   i_req    in   command, index, value
//   o_rsp    out  status, read_value, found_position, element_count
//
// Get, replace, push: at most one RAM access. Insert and remove: later
// entries move one at a time. Linear search reads in order, binary halves
// the range. Sort: each entry against each later one, single RAM read port.
// Reset clears the count, state and output valid, not the RAM; RAM contents beyond the count are never used.
// A result waiting on o_rsp holds the engine before its next result only.
// ----------------------------------------------------------------------------
module array_list_engine_unit #(
    parameter int DEPTH     = 128,
    parameter int WORD_BITS = 32
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ale_req_if.sink   i_req,
    ale_rsp_if.source o_rsp
);
    import ale_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [AW-1:0]        rd_addr, wr_addr;
    logic [WORD_BITS-1:0] rd_data, wr_data;
    logic                 we;

    ale_core #(.DEPTH(DEPTH), .WORD_BITS(WORD_BITS)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req       (i_req.data),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp       (o_rsp.data),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_we        (we),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    ale_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule
